/* hdl/utf8_repair_latin1_fallback_unit_assert.svh */
// assertion macros for the utf8 repair block and its checker
`ifndef UTF8_REPAIR_LATIN1_FALLBACK_UNIT_ASSERT_SVH
`define UTF8_REPAIR_LATIN1_FALLBACK_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define UTF8R_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 repair check failed");

// condition must hold in the cycle after the trigger
`define UTF8R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 repair check failed");

`endif

/* hdl/utf8r_pkg.sv */
`timescale 1ns / 1ps
package utf8r_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int HELD_DEPTH  = 3;

    // lead and continuation classification masks
    localparam logic [7:0] MASK_TOP1  = 8'h80;
    localparam logic [7:0] MASK_TOP3  = 8'hE0;
    localparam logic [7:0] MASK_TOP2  = 8'hC0;
    localparam logic [7:0] MASK_TOP4  = 8'hF0;
    localparam logic [7:0] MASK_TOP5  = 8'hF8;
    localparam logic [7:0] MASK_LOW6  = 8'h3F;
    localparam logic [7:0] PAT_ASCII  = 8'h00;
    localparam logic [7:0] PAT_CONT   = 8'h80;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;

    // sequence length codes
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_ONE = 3'd1;
    localparam logic [2:0] LEN_TWO = 3'd2;
    localparam logic [2:0] LEN_THR = 3'd3;
    localparam logic [2:0] LEN_FOU = 3'd4;

    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] held;
        logic [1:0]                 hcnt;
        logic [2:0]                 explen;
    } t_scan_state;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [CNT_W-1:0]            cnt;
    } t_burst;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] r;
        if ((c & MASK_TOP1) == PAT_ASCII)      r = LEN_ONE;
        else if ((c & MASK_TOP3) == PAT_LEAD2) r = LEN_TWO;
        else if ((c & MASK_TOP4) == PAT_LEAD3) r = LEN_THR;
        else if ((c & MASK_TOP5) == PAT_LEAD4) r = LEN_FOU;
        else                                   r = LEN_BAD;
        return r;
    endfunction

    function automatic logic is_cont(input logic [7:0] c);
        return (c & MASK_TOP2) == PAT_CONT;
    endfunction

    function automatic t_burst push(input t_burst l, input logic [7:0] b);
        t_burst r;
        r = l;
        if (l.cnt < CNT_W'(MAX_RESULTS)) begin
            r.data[l.cnt[$clog2(MAX_RESULTS)-1:0]] = b;
            r.cnt = l.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic t_burst push_latin1(input t_burst l, input logic [7:0] b);
        t_burst r;
        r = push(l, PAT_LEAD2 | {6'd0, b[7:6]});
        r = push(r, PAT_CONT | (b & MASK_LOW6));
        return r;
    endfunction

endpackage

/* hdl/utf8r_scan.sv */
`timescale 1ns / 1ps
module utf8r_scan (
    input  utf8r_pkg::t_scan_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output utf8r_pkg::t_scan_state o_state,
    output utf8r_pkg::t_burst      o_burst
);
    import utf8r_pkg::*;

    t_burst      burst;
    t_scan_state nxt;
    logic        as_lead;

    always_comb begin
        burst   = '0;
        nxt     = '0;
        nxt.held = i_state.held;
        as_lead = 1'b0;

        if (i_state.hcnt == 2'd0) begin
            as_lead = 1'b1;
        end else if (is_cont(i_byte)) begin
            if ({1'b0, i_state.hcnt} + 3'd1 == i_state.explen) begin
                // sequence complete, pass through
                for (int k = 0; k < HELD_DEPTH; k++) begin
                    if (2'(k) < i_state.hcnt) begin
                        burst = push(burst, i_state.held[k]);
                    end
                end
                burst = push(burst, i_byte);
            end else if (i_state.hcnt != 2'd3) begin
                nxt.held[i_state.hcnt] = i_byte;
                nxt.hcnt   = i_state.hcnt + 2'd1;
                nxt.explen = i_state.explen;
            end
        end else begin
            // broken sequence: lead and held continuations go out as latin-1
            for (int k = 0; k < HELD_DEPTH; k++) begin
                if (2'(k) < i_state.hcnt) begin
                    burst = push_latin1(burst, i_state.held[k]);
                end
            end
            as_lead = 1'b1;
        end

        if (as_lead) begin
            case (lead_len(i_byte))
                LEN_BAD: burst = push_latin1(burst, i_byte);
                LEN_ONE: burst = push(burst, i_byte);
                default: begin
                    nxt.held[0] = i_byte;
                    nxt.hcnt    = 2'd1;
                    nxt.explen  = lead_len(i_byte);
                end
            endcase
        end

        if (i_last) begin
            // cut off by line end
            for (int k = 0; k < HELD_DEPTH; k++) begin
                if (2'(k) < nxt.hcnt) begin
                    burst = push_latin1(burst, nxt.held[k]);
                end
            end
            nxt.hcnt   = 2'd0;
            nxt.explen = 3'd0;
        end
    end

    assign o_state = nxt;
    assign o_burst = burst;

endmodule

/* hdl/utf8r_emit.sv */
`timescale 1ns / 1ps
module utf8r_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  utf8r_pkg::t_burst i_burst,
    input  logic              i_line,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_run_last,
    output logic              o_line_end
);
    import utf8r_pkg::*;

    logic [MAX_RESULTS-1:0][7:0] r_data;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_line;
    logic                        pop;

    assign o_valid    = r_cnt != '0;
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_ready);
    assign o_byte     = r_data[0];
    assign o_run_last = r_cnt == CNT_W'(1);
    assign o_line_end = o_run_last && r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // payload: head at entry 0, shifts down on each request taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_burst.data;
            r_line <= i_line;
        end else if (pop) begin
            r_data <= {8'h00, r_data[MAX_RESULTS-1:1]};
        end
    end

endmodule

/* hdl/utf8_repair_latin1_fallback_unit.sv */
`timescale 1ns / 1ps
// UTF-8 repair with Latin-1 fallback. Raw line bytes come in one request per
// cycle while o_ready is high, with i_line_last on the final byte of a line;
// well-formed sequences (structural lead/continuation check only) leave
// unchanged, and any bad lead, broken sequence or sequence cut by the line end
// leaves with each affected byte re-encoded as a two-byte Latin-1 code. An
// input request yields 0 to 8 output requests: o_run_last marks the last of
// them and o_line_end the last of a line. Plain text flows at one byte per
// cycle while i_ready holds, each result shown in the cycle after its request
// is taken; a request with n results holds the output register until all n
// have left, and the next request is taken in the cycle its final result
// leaves. A request that only extends a pending sequence gives no result.
module utf8_repair_latin1_fallback_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_line_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_line_end
);
    import utf8r_pkg::*;

    // pending sequence: lead plus up to two continuations
    t_scan_state r_state;
    t_scan_state n_state;
    t_burst      burst;
    logic        can_load;
    logic        accept;

    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    utf8r_scan u_scan (
        .i_state (r_state),
        .i_byte  (i_in_byte),
        .i_last  (i_line_last),
        .o_state (n_state),
        .o_burst (burst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result register: loaded with the whole burst, drained one byte a cycle while i_ready is high
    utf8r_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_burst    (burst),
        .i_line     (i_line_last),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_byte     (o_out_byte),
        .o_run_last (o_run_last),
        .o_line_end (o_line_end)
    );

endmodule

/* hdl/utf8r_checker.sv */
`timescale 1ns / 1ps
`include "utf8_repair_latin1_fallback_unit_assert.svh"
module utf8r_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_line_last,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_line_end
);

    logic       line_take;
    logic       out_stall;
    logic       mid_take;
    logic [9:0] out_word;

    assign line_take = i_valid && o_ready && i_line_last;
    assign out_stall = o_valid && !i_ready;
    assign mid_take  = o_valid && i_ready && !o_run_last;
    assign out_word  = {o_out_byte, o_run_last, o_line_end};

    // a line end always closes a run
    `UTF8R_ASSERT_NOW(a_line_end_run, i_clk, i_rst_n, o_valid && o_line_end, o_run_last)

    // no new request taken while a result is stalled
    `UTF8R_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, out_stall, !o_ready)

    // a line-final request always produces a result next cycle
    `UTF8R_ASSERT_NEXT(a_line_gives_out, i_clk, i_rst_n, line_take, o_valid)

    // a run keeps going until its last byte
    `UTF8R_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, mid_take, o_valid)

    // stalled result holds
    `UTF8R_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(out_word))

endmodule

bind utf8_repair_latin1_fallback_unit utf8r_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_line_last (i_line_last),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last),
    .o_line_end  (o_line_end)
);
